FILE: sv/sgm_pkg.sv
package sgm_pkg;

	// map store and build work area
	localparam int MAX_MAP_UNITS = 8192;
	localparam int MAP_AW        = $clog2(MAX_MAP_UNITS);
	localparam int MAX_GROUPS    = 8;
	localparam int GRP_W         = 3;
	localparam int WORK_UNITS    = 65536;
	localparam int WORK_AW       = $clog2(WORK_UNITS);

	// commands
	localparam logic [2:0] CMD_LOAD_RUN  = 3'd0;
	localparam logic [2:0] CMD_LOAD_RECT = 3'd1;
	localparam logic [2:0] CMD_WRITE     = 3'd2;
	localparam logic [2:0] CMD_BUILD     = 3'd3;
	localparam logic [2:0] CMD_READ      = 3'd4;

	// map types
	localparam logic [2:0] MT_INTERLEAVED = 3'd0;
	localparam logic [2:0] MT_DISPERSED   = 3'd1;
	localparam logic [2:0] MT_FOREGROUND  = 3'd2;
	localparam logic [2:0] MT_BOXOUT      = 3'd3;
	localparam logic [2:0] MT_RASTER      = 3'd4;
	localparam logic [2:0] MT_WIPE        = 3'd5;

	// register indexes
	localparam logic [2:0] REG_PIC_WIDTH   = 3'd0;
	localparam logic [2:0] REG_PIC_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_NUM_GROUPS  = 3'd2;
	localparam logic [2:0] REG_MAP_TYPE    = 3'd3;
	localparam logic [2:0] REG_CHANGE_DIR  = 3'd4;
	localparam logic [2:0] REG_CHANGE_RATE = 3'd5;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [2:0]  group_index;
		logic [12:0] run_length_minus1;
		logic [12:0] top_left;
		logic [12:0] bottom_right;
		logic [12:0] map_address;
		logic [2:0]  explicit_group;
		logic [12:0] change_cycle;
	} sgm_req_t;

	typedef struct packed {
		logic [2:0] slice_group;
		logic       read_valid;
	} sgm_rsp_t;

	typedef struct packed {
		logic [7:0]  pic_width_mbs;
		logic [7:0]  pic_height_units;
		logic [2:0]  num_groups_minus1;
		logic [2:0]  map_type;
		logic        change_direction;
		logic [12:0] change_rate_minus1;
	} sgm_cfg_t;

	typedef struct packed {
		logic              en;
		logic [MAP_AW-1:0] addr;
		logic [GRP_W-1:0]  data;
	} sgm_wr_t;

	typedef struct packed {
		logic [12:0] run_length_minus1;
		logic [12:0] top_left;
		logic [12:0] bottom_right;
	} sgm_tab_t;

endpackage

FILE: sv/sgm_store.sv
module sgm_store (
	input  logic                              clk,
	input  sgm_pkg::sgm_wr_t                  wr,
	input  logic                              rd_en,
	input  logic [sgm_pkg::MAP_AW-1:0]        rd_addr,
	output logic [sgm_pkg::GRP_W-1:0]         rd_data
);
	import sgm_pkg::*;

	logic [GRP_W-1:0] mem [MAX_MAP_UNITS];
	logic [GRP_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		// read data holds until the next read
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

FILE: sv/sgm_div.sv
module sgm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [12:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [12:0] quot,
	output logic [7:0]  rem
);
	import sgm_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [12:0] dvd_q;
	logic [7:0]  rem_q;
	logic [7:0]  dsr_q;
	logic [8:0]  rem_sh;
	logic        ge;
	logic [8:0]  rem_nx;

	// restoring division, one quotient bit a cycle
	always_comb begin
		rem_sh = {rem_q, dvd_q[12]};
		ge     = rem_sh >= {1'b0, dsr_q};
		rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
			dvd_q  <= 13'd0;
			rem_q  <= 8'd0;
			dsr_q  <= 8'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd12;
				dvd_q  <= dividend;
				rem_q  <= 8'd0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[11:0], ge};
				rem_q <= rem_nx[7:0];
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

FILE: sv/sgm_builder.sv
module sgm_builder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sgm_pkg::sgm_cfg_t            cfg,
	input  logic                         start,
	input  logic [12:0]                  cycle,
	input  sgm_pkg::sgm_tab_t            tab,
	output logic [2:0]                   tab_idx,
	output sgm_pkg::sgm_wr_t             wr,
	output logic                         busy
);
	import sgm_pkg::*;

	localparam logic [4:0] ST_CLEAR   = 5'd0;
	localparam logic [4:0] ST_IDLE    = 5'd1;
	localparam logic [4:0] ST_SETUP1  = 5'd2;
	localparam logic [4:0] ST_SETUP2  = 5'd3;
	localparam logic [4:0] ST_FILL    = 5'd4;
	localparam logic [4:0] ST_WIPE    = 5'd5;
	localparam logic [4:0] ST_FG_TL   = 5'd6;
	localparam logic [4:0] ST_FG_TLW  = 5'd7;
	localparam logic [4:0] ST_FG_BR   = 5'd8;
	localparam logic [4:0] ST_FG_BRW  = 5'd9;
	localparam logic [4:0] ST_FG_CHK  = 5'd10;
	localparam logic [4:0] ST_FG_ROW  = 5'd11;
	localparam logic [4:0] ST_FG_RECT = 5'd12;
	localparam logic [4:0] ST_BX_ADDR = 5'd13;
	localparam logic [4:0] ST_BX_READ = 5'd14;
	localparam logic [4:0] ST_BX_UPD  = 5'd15;

	localparam logic [2:0] FK_ZERO   = 3'd0;
	localparam logic [2:0] FK_INTER  = 3'd1;
	localparam logic [2:0] FK_DISP   = 3'd2;
	localparam logic [2:0] FK_FORE   = 3'd3;
	localparam logic [2:0] FK_BOX    = 3'd4;
	localparam logic [2:0] FK_RASTER = 3'd5;

	logic [4:0]  state_q;
	logic [2:0]  fk_q;
	logic [12:0] cyc_q;
	logic [15:0] size_q;
	logic [26:0] prod_q;
	logic [9:0]  sum_q;
	logic [20:0] guard_q;
	logic [15:0] mu0_q;
	logic [15:0] ul_q;
	logic [15:0] i_q;
	logic [2:0]  g_q;
	logic [12:0] j_q;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [2:0]  v_q;
	logic [3:0]  h2_q;
	logic [15:0] addr_q;
	logic [15:0] rowbase_q;
	logic [12:0] yt_q;
	logic [7:0]  xt_q;
	logic [7:0]  yb_q;
	logic [7:0]  xb_q;
	logic [15:0] a_q;
	logic [7:0]  bx_q, by_q, lb_q, rb_q, tb_q, bb_q;
	logic signed [1:0] xd_q, yd_q;
	logic [15:0] k_q;
	logic [20:0] steps_q;

	// vacated marks for the box-out walk
	logic        bm_mem [WORK_UNITS];
	logic        bm_rd_q;
	logic        bm_we;
	logic [WORK_AW-1:0] bm_waddr;
	logic        bm_wdata;
	logic        bm_re;

	logic [7:0]  w, h, w_m1, h_m1;
	logic [2:0]  n;
	logic        d;
	logic        last_unit;
	logic [15:0] mu0_c, ul_c;
	logic [2:0]  dir_val;
	logic [2:0]  fill_val;
	logic [3:0]  m;
	logic [4:0]  h2n, h2w, two_m;
	logic [7:0]  bx0, by0;
	logic        div_start;
	logic [12:0] div_dvd;
	logic        div_done;
	logic [12:0] div_quot;
	logic [7:0]  div_rem;

	always_comb begin
		w         = cfg.pic_width_mbs;
		h         = cfg.pic_height_units;
		n         = cfg.num_groups_minus1;
		d         = cfg.change_direction;
		w_m1      = w - 8'd1;
		h_m1      = h - 8'd1;
		last_unit = i_q == (size_q - 16'd1);
		mu0_c     = (prod_q > {11'd0, size_q}) ? size_q : prod_q[15:0];
		ul_c      = d ? (size_q - mu0_c) : mu0_c;
		dir_val   = (i_q < ul_q) ? {2'b00, d} : {2'b00, ~d};
		m         = {1'b0, n} + 4'd1;
		two_m     = {m, 1'b0};
		h2n       = {1'b0, h2_q} + {1'b0, m};
		h2w       = (h2n >= two_m) ? (h2n - two_m) : h2n;
		bx0       = (w - {7'd0, d}) >> 1;
		by0       = (h - {7'd0, d}) >> 1;
		case (fk_q)
			FK_INTER:  fill_val = g_q;
			FK_DISP:   fill_val = v_q;
			FK_FORE:   fill_val = n;
			FK_BOX:    fill_val = 3'd1;
			FK_RASTER: fill_val = dir_val;
			default:   fill_val = 3'd0;
		endcase
	end

	// store write, bitmap and divider controls
	always_comb begin
		wr       = '0;
		bm_we    = 1'b0;
		bm_waddr = a_q[WORK_AW-1:0];
		bm_wdata = 1'b0;
		bm_re    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr.en   = 1'b1;
				wr.addr = i_q[MAP_AW-1:0];
			end
			ST_FILL: begin
				wr.en    = {1'b0, i_q} < 17'(MAX_MAP_UNITS);
				wr.addr  = i_q[MAP_AW-1:0];
				wr.data  = fill_val;
				bm_we    = fk_q == FK_BOX;
				bm_waddr = i_q[WORK_AW-1:0];
				bm_wdata = 1'b1;
			end
			ST_WIPE: begin
				wr.en   = {1'b0, addr_q} < 17'(MAX_MAP_UNITS);
				wr.addr = addr_q[MAP_AW-1:0];
				wr.data = dir_val;
			end
			ST_FG_RECT: begin
				wr.en   = {1'b0, addr_q} < 17'(MAX_MAP_UNITS);
				wr.addr = addr_q[MAP_AW-1:0];
				wr.data = g_q;
			end
			ST_BX_READ: begin
				bm_re = 1'b1;
			end
			ST_BX_UPD: begin
				wr.en   = bm_rd_q && ({1'b0, a_q} < 17'(MAX_MAP_UNITS));
				wr.addr = a_q[MAP_AW-1:0];
				bm_we   = bm_rd_q;
			end
			default: begin
			end
		endcase
	end

	assign div_start = (state_q == ST_FG_TL) || (state_q == ST_FG_BR);
	assign div_dvd   = (state_q == ST_FG_TL) ? tab.top_left : tab.bottom_right;
	assign tab_idx   = g_q;
	assign busy      = state_q != ST_IDLE;

	sgm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (w),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		if (bm_re) begin
			bm_rd_q <= bm_mem[a_q[WORK_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			fk_q      <= FK_ZERO;
			cyc_q     <= '0;
			size_q    <= '0;
			prod_q    <= '0;
			sum_q     <= '0;
			guard_q   <= '0;
			mu0_q     <= '0;
			ul_q      <= '0;
			i_q       <= '0;
			g_q       <= '0;
			j_q       <= '0;
			x_q       <= '0;
			y_q       <= '0;
			v_q       <= '0;
			h2_q      <= '0;
			addr_q    <= '0;
			rowbase_q <= '0;
			yt_q      <= '0;
			xt_q      <= '0;
			yb_q      <= '0;
			xb_q      <= '0;
			a_q       <= '0;
			bx_q      <= '0;
			by_q      <= '0;
			lb_q      <= '0;
			rb_q      <= '0;
			tb_q      <= '0;
			bb_q      <= '0;
			xd_q      <= '0;
			yd_q      <= '0;
			k_q       <= '0;
			steps_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (i_q == 16'(MAX_MAP_UNITS - 1)) begin
						i_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						i_q <= i_q + 16'd1;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cyc_q   <= cycle;
						state_q <= ST_SETUP1;
					end
				end
				ST_SETUP1: begin
					size_q  <= {8'd0, w} * {8'd0, h};
					prod_q  <= 27'(cyc_q) * 27'({1'b0, cfg.change_rate_minus1} + 14'd1);
					sum_q   <= 10'(w) + 10'(h) + 10'd2;
					state_q <= ST_SETUP2;
				end
				ST_SETUP2: begin
					guard_q <= (21'(sum_q) * 21'(sum_q)) << 2;
					mu0_q   <= mu0_c;
					ul_q    <= ul_c;
					i_q     <= '0;
					g_q     <= '0;
					j_q     <= '0;
					x_q     <= '0;
					y_q     <= '0;
					v_q     <= '0;
					h2_q    <= '0;
					addr_q  <= '0;
					if (size_q == 16'd0) begin
						state_q <= ST_IDLE;
					end else if (n == 3'd0) begin
						fk_q    <= FK_ZERO;
						state_q <= ST_FILL;
					end else begin
						case (cfg.map_type)
							MT_INTERLEAVED: begin
								fk_q    <= FK_INTER;
								state_q <= ST_FILL;
							end
							MT_DISPERSED: begin
								fk_q    <= FK_DISP;
								state_q <= ST_FILL;
							end
							MT_FOREGROUND: begin
								fk_q    <= FK_FORE;
								state_q <= ST_FILL;
							end
							MT_BOXOUT: begin
								fk_q    <= FK_BOX;
								state_q <= ST_FILL;
							end
							MT_RASTER: begin
								fk_q    <= FK_RASTER;
								state_q <= ST_FILL;
							end
							MT_WIPE: begin
								state_q <= ST_WIPE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_FILL: begin
					if (fk_q == FK_INTER) begin
						if (j_q == tab.run_length_minus1) begin
							j_q <= '0;
							g_q <= (g_q == n) ? 3'd0 : (g_q + 3'd1);
						end else begin
							j_q <= j_q + 13'd1;
						end
					end
					if (fk_q == FK_DISP) begin
						if (x_q == w_m1) begin
							x_q  <= '0;
							h2_q <= h2w[3:0];
							v_q  <= h2w[3:1];
						end else begin
							x_q <= x_q + 8'd1;
							v_q <= (v_q == n) ? 3'd0 : (v_q + 3'd1);
						end
					end
					if (last_unit) begin
						case (fk_q)
							FK_FORE: begin
								g_q     <= n - 3'd1;
								state_q <= ST_FG_TL;
							end
							FK_BOX: begin
								bx_q    <= bx0;
								lb_q    <= bx0;
								rb_q    <= bx0;
								by_q    <= by0;
								tb_q    <= by0;
								bb_q    <= by0;
								xd_q    <= d ? 2'sd0 : -2'sd1;
								yd_q    <= d ? 2'sd1 : 2'sd0;
								k_q     <= '0;
								steps_q <= '0;
								state_q <= ST_BX_ADDR;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end else begin
						i_q <= i_q + 16'd1;
					end
				end
				ST_WIPE: begin
					if (last_unit) begin
						state_q <= ST_IDLE;
					end else begin
						i_q <= i_q + 16'd1;
					end
					if (y_q == h_m1) begin
						y_q    <= '0;
						x_q    <= x_q + 8'd1;
						addr_q <= 16'(x_q) + 16'd1;
					end else begin
						y_q    <= y_q + 8'd1;
						addr_q <= addr_q + 16'(w);
					end
				end
				ST_FG_TL: begin
					state_q <= ST_FG_TLW;
				end
				ST_FG_TLW: begin
					if (div_done) begin
						yt_q    <= div_quot;
						xt_q    <= div_rem;
						state_q <= ST_FG_BR;
					end
				end
				ST_FG_BR: begin
					state_q <= ST_FG_BRW;
				end
				ST_FG_BRW: begin
					if (div_done) begin
						yb_q    <= (div_quot > 13'(h_m1)) ? h_m1 : div_quot[7:0];
						xb_q    <= div_rem;
						state_q <= ST_FG_CHK;
					end
				end
				ST_FG_CHK: begin
					if ((yt_q <= 13'(yb_q)) && (xt_q <= xb_q)) begin
						rowbase_q <= 16'(yt_q[7:0]) * 16'(w);
						y_q       <= yt_q[7:0];
						x_q       <= xt_q;
						state_q   <= ST_FG_ROW;
					end else if (g_q == 3'd0) begin
						state_q <= ST_IDLE;
					end else begin
						g_q     <= g_q - 3'd1;
						state_q <= ST_FG_TL;
					end
				end
				ST_FG_ROW: begin
					addr_q  <= rowbase_q + 16'(xt_q);
					state_q <= ST_FG_RECT;
				end
				ST_FG_RECT: begin
					if (x_q == xb_q) begin
						if (y_q == yb_q) begin
							if (g_q == 3'd0) begin
								state_q <= ST_IDLE;
							end else begin
								g_q     <= g_q - 3'd1;
								state_q <= ST_FG_TL;
							end
						end else begin
							y_q       <= y_q + 8'd1;
							rowbase_q <= rowbase_q + 16'(w);
							addr_q    <= rowbase_q + 16'(w) + 16'(xt_q);
							x_q       <= xt_q;
						end
					end else begin
						x_q    <= x_q + 8'd1;
						addr_q <= addr_q + 16'd1;
					end
				end
				ST_BX_ADDR: begin
					if ((k_q < mu0_q) && (steps_q < guard_q)) begin
						a_q     <= 16'(by_q) * 16'(w) + 16'(bx_q);
						state_q <= ST_BX_READ;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_BX_READ: begin
					state_q <= ST_BX_UPD;
				end
				ST_BX_UPD: begin
					steps_q <= steps_q + 21'd1;
					k_q     <= k_q + 16'(bm_rd_q);
					state_q <= ST_BX_ADDR;
					if ((xd_q == -2'sd1) && (bx_q == lb_q)) begin
						lb_q <= (lb_q == 8'd0) ? 8'd0 : (lb_q - 8'd1);
						bx_q <= (lb_q == 8'd0) ? 8'd0 : (lb_q - 8'd1);
						xd_q <= 2'sd0;
						yd_q <= d ? 2'sd1 : -2'sd1;
					end else if ((xd_q == 2'sd1) && (bx_q == rb_q)) begin
						rb_q <= (rb_q == w_m1) ? rb_q : (rb_q + 8'd1);
						bx_q <= (rb_q == w_m1) ? rb_q : (rb_q + 8'd1);
						xd_q <= 2'sd0;
						yd_q <= d ? -2'sd1 : 2'sd1;
					end else if ((yd_q == -2'sd1) && (by_q == tb_q)) begin
						tb_q <= (tb_q == 8'd0) ? 8'd0 : (tb_q - 8'd1);
						by_q <= (tb_q == 8'd0) ? 8'd0 : (tb_q - 8'd1);
						xd_q <= d ? -2'sd1 : 2'sd1;
						yd_q <= 2'sd0;
					end else if ((yd_q == 2'sd1) && (by_q == bb_q)) begin
						bb_q <= (bb_q == h_m1) ? bb_q : (bb_q + 8'd1);
						by_q <= (bb_q == h_m1) ? bb_q : (bb_q + 8'd1);
						xd_q <= d ? 2'sd1 : -2'sd1;
						yd_q <= 2'sd0;
					end else begin
						bx_q <= bx_q + {{6{xd_q[1]}}, xd_q};
						by_q <= by_q + {{6{yd_q[1]}}, yd_q};
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/slice_group_map_generator.sv
// slice group map generator
// request channel (req_valid, req_stall, req): one transaction per command. loads fill the
// per-group run-length and rectangle tables, writes set one unit of the explicit map, a
// build walks the whole map into the store and a read looks up one unit.
// response channel (rsp_valid, rsp_stall, rsp): exactly one transaction per request, in
// order; slice_group and read_valid are zero for everything but a read.
// a response passes through stage 1 and the output register; loads, writes and reads go at
// one per cycle unless rsp_stall holds them back, each taking one slot in stage 1, and writes
// and reads a single store access. a build holds req_stall high while the sequencer walks
// the map: a pass over the picture for most types, plus two divisions and the rectangle area
// per group for foreground, and an address, read and update step per spiral step for box-out.
// after reset the store is swept to zero, one unit a cycle over all 8192 units; requests are
// stalled meanwhile, the register port works as ever.
// a stalled response holds in the output register while one more result waits in the stage
// behind it; apart from builds and the reset sweep, requests stall only when both are full.
// apb registers sit at byte addresses 4*i; the user must write them only while idle, unchecked.
module slice_group_map_generator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sgm_pkg::sgm_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sgm_pkg::sgm_rsp_t rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import sgm_pkg::*;

	sgm_cfg_t cfg_q;

	// per-group tables, undefined until loaded
	logic [12:0] rl_q [MAX_GROUPS];
	logic [12:0] tl_q [MAX_GROUPS];
	logic [12:0] br_q [MAX_GROUPS];

	logic        cfg_wr;
	logic        req_acc;
	logic        s1_adv;
	logic        valid_s1;
	logic        rd_s1;
	logic        use_s1;
	logic        rsp_valid_q;
	sgm_rsp_t    rsp_q;

	logic        bld_start;
	logic        bld_busy;
	sgm_wr_t     bld_wr;
	sgm_tab_t    bld_tab;
	logic [2:0]  bld_idx;
	sgm_wr_t     map_wr;
	logic        map_rd_en;
	logic [GRP_W-1:0] map_rd;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[4:2])
			REG_PIC_WIDTH:   prdata = {24'd0, cfg_q.pic_width_mbs};
			REG_PIC_HEIGHT:  prdata = {24'd0, cfg_q.pic_height_units};
			REG_NUM_GROUPS:  prdata = {29'd0, cfg_q.num_groups_minus1};
			REG_MAP_TYPE:    prdata = {29'd0, cfg_q.map_type};
			REG_CHANGE_DIR:  prdata = {31'd0, cfg_q.change_direction};
			REG_CHANGE_RATE: prdata = {19'd0, cfg_q.change_rate_minus1};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pic_width_mbs      <= 8'd1;
			cfg_q.pic_height_units   <= 8'd1;
			cfg_q.num_groups_minus1  <= 3'd0;
			cfg_q.map_type           <= 3'd0;
			cfg_q.change_direction   <= 1'b0;
			cfg_q.change_rate_minus1 <= 13'd0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_PIC_WIDTH:   cfg_q.pic_width_mbs      <= pwdata[7:0];
				REG_PIC_HEIGHT:  cfg_q.pic_height_units   <= pwdata[7:0];
				REG_NUM_GROUPS:  cfg_q.num_groups_minus1  <= pwdata[2:0];
				REG_MAP_TYPE:    cfg_q.map_type           <= pwdata[2:0];
				REG_CHANGE_DIR:  cfg_q.change_direction   <= pwdata[0];
				REG_CHANGE_RATE: cfg_q.change_rate_minus1 <= pwdata[12:0];
				default: begin
				end
			endcase
		end
	end

	// request side: stall while the sequencer is busy (build or reset sweep) or both result slots are full
	assign s1_adv    = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = bld_busy || (valid_s1 && !s1_adv);
	assign req_acc   = req_valid && !req_stall;

	always_ff @(posedge clk) begin
		if (req_acc && (req.cmd == CMD_LOAD_RUN)) begin
			rl_q[req.group_index] <= req.run_length_minus1;
		end
		if (req_acc && (req.cmd == CMD_LOAD_RECT)) begin
			tl_q[req.group_index] <= req.top_left;
			br_q[req.group_index] <= req.bottom_right;
		end
	end

	assign bld_tab.run_length_minus1 = rl_q[bld_idx];
	assign bld_tab.top_left          = tl_q[bld_idx];
	assign bld_tab.bottom_right      = br_q[bld_idx];

	assign bld_start = req_acc && (req.cmd == CMD_BUILD);
	assign map_rd_en = req_acc && (req.cmd == CMD_READ);

	// explicit writes only arrive while the sequencer is idle
	always_comb begin
		if (bld_wr.en) begin
			map_wr = bld_wr;
		end else begin
			map_wr.en   = req_acc && (req.cmd == CMD_WRITE);
			map_wr.addr = req.map_address;
			map_wr.data = req.explicit_group;
		end
	end

	sgm_builder u_builder (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.start   (bld_start),
		.cycle   (req.change_cycle),
		.tab     (bld_tab),
		.tab_idx (bld_idx),
		.wr      (bld_wr),
		.busy    (bld_busy)
	);

	sgm_store u_store (
		.clk     (clk),
		.wr      (map_wr),
		.rd_en   (map_rd_en),
		.rd_addr (req.map_address),
		.rd_data (map_rd)
	);

	// stage 1 waits on the store read; the output register faces the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rd_s1       <= 1'b0;
			use_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (req_acc) begin
				valid_s1 <= 1'b1;
				rd_s1    <= req.cmd == CMD_READ;
				use_s1   <= cfg_q.num_groups_minus1 != 3'd0;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q       <= 1'b1;
				rsp_q.slice_group <= (rd_s1 && use_s1) ? map_rd : 3'd0;
				rsp_q.read_valid  <= rd_s1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_bld_excl: assert property (@(posedge clk) disable iff (!arst_n)
		bld_wr.en |-> !req_acc)
		else $error("sequencer write while a transaction is accepted");

	a_bld_start: assert property (@(posedge clk) disable iff (!arst_n)
		bld_start |=> bld_busy)
		else $error("build accepted but sequencer not busy");

	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> valid_s1)
		else $error("accepted transaction missing from stage 1");

	a_rd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		map_rd_en |-> !bld_busy)
		else $error("store read during build");

endmodule
